/* rtl/sdot_pkg.sv */
package sdot_pkg;

   // Configuration register indexes (byte address = 4 * index).
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_ENABLE       = 3'd0;
   localparam logic [2:0] REG_INVERSE_MODE = 3'd1;
   localparam logic [2:0] REG_GEAR_PERCENT = 3'd2;
   localparam logic [2:0] REG_LONG_DELAY   = 3'd3;
   localparam logic [2:0] REG_DELAY_MS     = 3'd4;

   // Fixed arithmetic constants of the protection function.
   localparam int PHASE_COUNT   = 3;
   localparam int DISTURB_LIMIT = 5;
   localparam int PCT_SCALE     = 100;
   localparam int PICKUP_DIV    = 10000;
   localparam int MS_PER_S      = 1000;
   localparam int HEAT_SCALE    = 10000;
   localparam int CD_MAX        = 4095;
   localparam int FRAC_BITS     = 16;

   // Serial arithmetic unit sizes.
   localparam int MUL_A_W   = 64;
   localparam int MUL_B_W   = 32;
   localparam int MUL_STEPS = 32;
   localparam int NUM_W     = 80;
   localparam int DEN_W     = 64;
   localparam int Q_W       = 48;
   localparam int DIV_STEPS = 80;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_cmd_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PK_MUL,
      ST_PK_DIV,
      ST_BASE_DIV,
      ST_G_MUL,
      ST_D_MUL,
      ST_PHASE,
      ST_SQ_MUL,
      ST_N_MUL,
      ST_INC_DIV,
      ST_DONE
   } state_type;

endpackage

/* rtl/sdot_if.sv */
interface sdot_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [15:0] current_a;
   logic [15:0] current_b;
   logic [15:0] current_c;
   logic [9:0]  extra_delay_a;
   logic [9:0]  extra_delay_b;
   logic [9:0]  extra_delay_c;
   logic        breaker_accepts;

   modport source (output valid, cmd, current_a, current_b, current_c,
                   extra_delay_a, extra_delay_b, extra_delay_c, breaker_accepts,
                   input ready);
   modport sink (input valid, cmd, current_a, current_b, current_c,
                 extra_delay_a, extra_delay_b, extra_delay_c, breaker_accepts,
                 output ready);
endinterface

interface sdot_rsp_if;
   logic       valid;
   logic       ready;
   logic       protected_res;
   logic [1:0] trip_phase;
   logic [2:0] heating_mask;

   modport source (output valid, protected_res, trip_phase, heating_mask, input ready);
   modport sink (input valid, protected_res, trip_phase, heating_mask, output ready);
endinterface

/* rtl/sdot_smul.sv */
module sdot_smul (
   input  logic                  clock,
   input  logic                  reset,
   input  sdot_pkg::mul_cmd_type cmd,
   output sdot_pkg::unit_stat_type stat,
   output logic [63:0]           product
);
   import sdot_pkg::*;

   logic [MUL_A_W-1:0] acc_ff, acc_in;
   logic [MUL_A_W-1:0] mcand_ff, mcand_in;
   logic [MUL_B_W-1:0] mplier_ff, mplier_in;
   logic [5:0]         count_ff, count_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   // Shift-add: one multiplier bit per cycle.
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (cmd.start) begin
         acc_in    = '0;
         mcand_in  = cmd.a;
         mplier_in = cmd.b;
         count_in  = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[MUL_A_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[MUL_B_W-1:1]};
         count_in  = count_ff + 6'd1;
         if (count_ff == 6'(MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      count_ff  <= count_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = acc_ff;
endmodule

/* rtl/sdot_sdiv.sv */
module sdot_sdiv (
   input  logic                    clock,
   input  logic                    reset,
   input  sdot_pkg::div_cmd_type   cmd,
   output sdot_pkg::unit_stat_type stat,
   output logic [47:0]             quotient
);
   import sdot_pkg::*;

   logic [DEN_W:0]   rem_ff, rem_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [6:0]       count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;

   // Restoring division: one quotient bit per cycle, numerator shifted in MSB first.
   assign trial = {rem_ff[DEN_W-1:0], num_ff[NUM_W-1]};

   always_comb begin
      rem_in   = rem_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         rem_in   = '0;
         num_in   = cmd.num;
         quo_in   = '0;
         den_in   = cmd.den;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         count_in = count_ff + 7'd1;
         if (count_ff == 7'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      count_ff <= count_in;
   end

   // A quotient beyond 48 bits, or a zero divisor, saturates to all ones.
   assign quotient  = (|quo_ff[NUM_W-1:Q_W]) ? '1 : quo_ff[Q_W-1:0];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
endmodule

/* rtl/short_delay_overcurrent_trip_unit.sv */
// Channel   Direction  Handshake          Word
// req_bus   in         valid/ready        cmd, three currents, three extra delays, accept
// rsp_bus   out        valid/ready        protected_res, trip_phase, heating_mask
// csr_*     in/out     APB, pready high   five registers at byte address 4*i
//
// A clear, disabled or latched word goes from idle straight to the final state.
// An evaluated word runs a shift-add multiplier and a restoring divider in series,
// first for the pickup and base delay; in inverse mode they may run again for a phase above pickup.
// Reset is synchronous and clears the sequencer, protection and configuration state.
// A new word is taken while a finished result still waits in the output register;
// the sequencer holds in its final state until that register is free.
module short_delay_overcurrent_trip_unit #(
   parameter int PICKUP_PERCENT = 100,
   parameter int TRIP_COST_MS   = 25,
   parameter int SAMPLE_HZ      = 50,
   parameter int HEAT_MAX       = 1000,
   parameter int HEAT_STEP      = 1000,
   parameter int HEAT_DECAY     = 1
) (
   input  logic                            clock,
   input  logic                            reset,
   sdot_req_if.sink                        req_bus,
   sdot_rsp_if.source                      rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [sdot_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import sdot_pkg::*;

   localparam int PERIOD_RAW = MS_PER_S / SAMPLE_HZ;
   localparam int PERIOD     = (PERIOD_RAW == 0) ? 1 : PERIOD_RAW;
   localparam logic [31:0] HEAT_MUL   = 32'(HEAT_STEP * HEAT_SCALE);
   localparam logic [47:0] HEAT_LIMIT = 48'(HEAT_MAX) << FRAC_BITS;
   localparam logic [47:0] HEAT_DEC   = 48'(HEAT_DECAY) << FRAC_BITS;

   // Configuration registers.
   logic        enable_ff, inverse_ff;
   logic [10:0] gear_ff;
   logic [12:0] ir1_ff;
   logic [9:0]  delay_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   // Captured word.
   logic [15:0] cur_ff   [PHASE_COUNT];
   logic [9:0]  extra_ff [PHASE_COUNT];
   logic        accept_ff;
   logic        req_take;

   // Per-word derived values.
   logic [23:0] gi_ff, gi_in;
   logic [15:0] pickup_ff, pickup_in;
   logic [9:0]  base_ff, base_in;
   logic [63:0] den_ff, den_in;

   // Protection state.
   logic [47:0] heat_ff [PHASE_COUNT];
   logic [47:0] heat_in [PHASE_COUNT];
   logic [11:0] cd_ff   [PHASE_COUNT];
   logic [11:0] cd_in   [PHASE_COUNT];
   logic [2:0]  dc_ff   [PHASE_COUNT];
   logic [2:0]  dc_in   [PHASE_COUNT];
   logic [2:0]  counting_ff, counting_in;
   logic        latch_ff, latch_in;
   logic [2:0]  mask_ff, mask_in;

   // Sequencer.
   state_type   state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic        res_ff, res_in;
   logic [1:0]  req_ff, req_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_res_ff, rsp_res_in;
   logic [1:0]  rsp_phase_ff, rsp_phase_in;
   logic [2:0]  rsp_mask_ff, rsp_mask_in;

   // Arithmetic units.
   mul_cmd_type   mul_cmd;
   unit_stat_type mul_stat;
   logic [63:0]   mul_product;
   div_cmd_type   div_cmd;
   unit_stat_type div_stat;
   logic [47:0]   div_quo;

   // Phase-local views.
   logic [15:0] cur_sel;
   logic [9:0]  extra_sel;
   logic [11:0] total_sel;
   logic [11:0] cd_sel;
   logic [47:0] heat_sel;
   logic [2:0]  dc_next;
   logic [26:0] g_val;
   logic [22:0] cur_x100;
   logic        above, over_gear, last_phase;
   logic [9:0]  diff;
   logic [31:0] pk_num;
   logic [48:0] heat_sum;
   logic [47:0] heat_new;
   logic [1:0]  phase_code;

   sdot_smul u_mul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul_cmd),
      .stat    (mul_stat),
      .product (mul_product)
   );

   sdot_sdiv u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         inverse_ff <= 1'b0;
         gear_ff    <= 11'd600;
         ir1_ff     <= 13'd0;
         delay_ff   <= 10'd300;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_ENABLE:       enable_ff  <= csr_pwdata[0];
            REG_INVERSE_MODE: inverse_ff <= csr_pwdata[0];
            REG_GEAR_PERCENT: gear_ff    <= csr_pwdata[10:0];
            REG_LONG_DELAY:   ir1_ff     <= csr_pwdata[12:0];
            REG_DELAY_MS:     delay_ff   <= csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_ENABLE:       csr_prdata = {31'd0, enable_ff};
         REG_INVERSE_MODE: csr_prdata = {31'd0, inverse_ff};
         REG_GEAR_PERCENT: csr_prdata = {21'd0, gear_ff};
         REG_LONG_DELAY:   csr_prdata = {19'd0, ir1_ff};
         REG_DELAY_MS:     csr_prdata = {22'd0, delay_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // Word capture.
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid & req_bus.ready;

   always_ff @(posedge clock) begin
      if (req_take) begin
         cur_ff[0]   <= req_bus.current_a;
         cur_ff[1]   <= req_bus.current_b;
         cur_ff[2]   <= req_bus.current_c;
         extra_ff[0] <= req_bus.extra_delay_a;
         extra_ff[1] <= req_bus.extra_delay_b;
         extra_ff[2] <= req_bus.extra_delay_c;
         accept_ff   <= req_bus.breaker_accepts;
      end
   end

   // Values for the phase under evaluation. Base and extra delay stay below 4096.
   assign cur_sel    = cur_ff[phase_ff];
   assign extra_sel  = extra_ff[phase_ff];
   assign total_sel  = 12'(11'(base_ff) + 11'(extra_sel));
   assign cd_sel     = cd_ff[phase_ff];
   assign heat_sel   = heat_ff[phase_ff];
   assign dc_next    = dc_ff[phase_ff] + 3'd1;
   assign g_val      = {gi_ff, 3'b000};
   assign cur_x100   = 23'(32'(cur_sel) * 32'(PCT_SCALE));
   assign above      = cur_sel > pickup_ff;
   assign over_gear  = {5'd0, cur_x100} > {1'b0, g_val};
   assign last_phase = phase_ff == 2'(PHASE_COUNT - 1);
   assign phase_code = phase_ff + 2'd1;
   assign diff       = (32'(delay_ff) > 32'(TRIP_COST_MS)) ?
                       10'(32'(delay_ff) - 32'(TRIP_COST_MS)) : 10'd0;
   assign pk_num     = 32'(64'(mul_product[23:0]) * 64'(PICKUP_PERCENT));
   assign heat_sum   = {1'b0, heat_sel} + {1'b0, div_quo};
   assign heat_new   = heat_sum[48] ? '1 : heat_sum[47:0];

   // Sequencer: next state, protection state updates and unit starts.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      res_in       = res_ff;
      req_in       = req_ff;
      gi_in        = gi_ff;
      pickup_in    = pickup_ff;
      base_in      = base_ff;
      den_in       = den_ff;
      heat_in      = heat_ff;
      cd_in        = cd_ff;
      dc_in        = dc_ff;
      counting_in  = counting_ff;
      latch_in     = latch_ff;
      mask_in      = mask_ff;
      mul_cmd      = '0;
      div_cmd      = '0;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      rsp_res_in   = rsp_res_ff;
      rsp_phase_in = rsp_phase_ff;
      rsp_mask_in  = rsp_mask_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               res_in   = 1'b0;
               req_in   = 2'd0;
               phase_in = 2'd0;
               if (req_bus.cmd) begin
                  latch_in = 1'b0;
                  state_in = ST_DONE;
               end else if (!enable_ff) begin
                  for (int i = 0; i < PHASE_COUNT; i++) begin
                     heat_in[i] = '0;
                     cd_in[i]   = '0;
                     dc_in[i]   = '0;
                  end
                  counting_in = '0;
                  mask_in     = '0;
                  state_in    = ST_DONE;
               end else if (latch_ff) begin
                  res_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  mul_cmd.start = 1'b1;
                  mul_cmd.a     = 64'(gear_ff);
                  mul_cmd.b     = 32'(ir1_ff);
                  state_in      = ST_PK_MUL;
               end
            end
         end

         // Pickup = gear * Ir1 * percent / 10000.
         ST_PK_MUL: begin
            if (mul_stat.done) begin
               gi_in         = mul_product[23:0];
               div_cmd.start = 1'b1;
               div_cmd.num   = 80'(pk_num);
               div_cmd.den   = 64'(PICKUP_DIV);
               state_in      = ST_PK_DIV;
            end
         end

         ST_PK_DIV: begin
            if (div_stat.done) begin
               pickup_in     = (|div_quo[47:16]) ? 16'hFFFF : div_quo[15:0];
               div_cmd.start = 1'b1;
               div_cmd.num   = 80'(diff);
               div_cmd.den   = 64'(PERIOD);
               state_in      = ST_BASE_DIV;
            end
         end

         // Base delay count, then the I2t divisor when in inverse mode.
         ST_BASE_DIV: begin
            if (div_stat.done) begin
               base_in = (div_quo[9:0] == 10'd0) ? 10'd0 : div_quo[9:0] - 10'd1;
               if (inverse_ff) begin
                  mul_cmd.start = 1'b1;
                  mul_cmd.a     = 64'(g_val);
                  mul_cmd.b     = 32'(g_val);
                  state_in      = ST_G_MUL;
               end else begin
                  state_in = ST_PHASE;
               end
            end
         end

         ST_G_MUL: begin
            if (mul_stat.done) begin
               mul_cmd.start = 1'b1;
               mul_cmd.a     = mul_product;
               mul_cmd.b     = 32'(delay_ff);
               state_in      = ST_D_MUL;
            end
         end

         ST_D_MUL: begin
            if (mul_stat.done) begin
               den_in   = mul_product;
               state_in = ST_PHASE;
            end
         end

         // One phase per visit.
         ST_PHASE: begin
            if (!inverse_ff) begin
               heat_in[phase_ff] = '0;
            end
            if (above) begin
               if (!inverse_ff || over_gear) begin
                  if (!counting_ff[phase_ff]) begin
                     counting_in[phase_ff] = 1'b1;
                     cd_in[phase_ff]       = total_sel;
                     mask_in[phase_ff]     = 1'b1;
                  end else if (cd_sel <= 12'd1) begin
                     req_in = phase_code;
                     if (accept_ff) begin
                        cd_in[phase_ff] = '0;
                        latch_in        = 1'b1;
                        res_in          = 1'b1;
                     end else begin
                        counting_in[phase_ff] = 1'b0;
                        cd_in[phase_ff]       = total_sel;
                        mask_in[phase_ff]     = 1'b1;
                     end
                  end else begin
                     cd_in[phase_ff]   = cd_sel - 12'd1;
                     mask_in[phase_ff] = 1'b1;
                  end
                  if ((cd_sel <= 12'd1) && counting_ff[phase_ff] && accept_ff) begin
                     state_in = ST_DONE;
                  end else if (last_phase) begin
                     state_in = ST_DONE;
                  end else begin
                     phase_in = phase_ff + 2'd1;
                  end
               end else begin
                  mul_cmd.start = 1'b1;
                  mul_cmd.a     = 64'(cur_sel);
                  mul_cmd.b     = 32'(cur_sel);
                  state_in      = ST_SQ_MUL;
               end
            end else begin
               if (inverse_ff) begin
                  heat_in[phase_ff] = (heat_sel > HEAT_DEC) ? heat_sel - HEAT_DEC : '0;
               end else if (counting_ff[phase_ff]) begin
                  if (32'(dc_next) >= 32'(DISTURB_LIMIT)) begin
                     if ((cd_sel <= total_sel) && (cd_sel < 12'(CD_MAX))) begin
                        cd_in[phase_ff] = cd_sel + 12'd1;
                     end
                     dc_in[phase_ff] = '0;
                  end else begin
                     dc_in[phase_ff] = dc_next;
                  end
               end else begin
                  dc_in[phase_ff] = '0;
               end
               mask_in[phase_ff] = 1'b0;
               if (last_phase) begin
                  state_in = ST_DONE;
               end else begin
                  phase_in = phase_ff + 2'd1;
               end
            end
         end

         // I2t increment = step * 10000 * I^2 * 2^16 / (g^2 * delay).
         ST_SQ_MUL: begin
            if (mul_stat.done) begin
               mul_cmd.start = 1'b1;
               mul_cmd.a     = mul_product;
               mul_cmd.b     = HEAT_MUL;
               state_in      = ST_N_MUL;
            end
         end

         ST_N_MUL: begin
            if (mul_stat.done) begin
               div_cmd.start = 1'b1;
               div_cmd.num   = {mul_product, 16'h0000};
               div_cmd.den   = den_ff;
               state_in      = ST_INC_DIV;
            end
         end

         ST_INC_DIV: begin
            if (div_stat.done) begin
               heat_in[phase_ff] = heat_new;
               if (heat_new >= HEAT_LIMIT) begin
                  req_in = phase_code;
               end
               if ((heat_new >= HEAT_LIMIT) && accept_ff) begin
                  latch_in = 1'b1;
                  res_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  mask_in[phase_ff] = 1'b1;
                  if (last_phase) begin
                     state_in = ST_DONE;
                  end else begin
                     phase_in = phase_ff + 2'd1;
                     state_in = ST_PHASE;
                  end
               end
            end
         end

         // Hand the result to the output register once it is free.
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_ff;
               rsp_phase_in = req_ff;
               rsp_mask_in  = mask_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 2'd0;
         res_ff       <= 1'b0;
         req_ff       <= 2'd0;
         latch_ff     <= 1'b0;
         mask_ff      <= 3'd0;
         counting_ff  <= 3'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PHASE_COUNT; i++) begin
            heat_ff[i] <= '0;
            cd_ff[i]   <= '0;
            dc_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         res_ff       <= res_in;
         req_ff       <= req_in;
         latch_ff     <= latch_in;
         mask_ff      <= mask_in;
         counting_ff  <= counting_in;
         rsp_valid_ff <= rsp_valid_in;
         heat_ff      <= heat_in;
         cd_ff        <= cd_in;
         dc_ff        <= dc_in;
      end
      gi_ff        <= gi_in;
      pickup_ff    <= pickup_in;
      base_ff      <= base_in;
      den_ff       <= den_in;
      rsp_res_ff   <= rsp_res_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_mask_ff  <= rsp_mask_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.protected_res = rsp_res_ff;
   assign rsp_bus.trip_phase    = rsp_phase_ff;
   assign rsp_bus.heating_mask  = rsp_mask_ff;

   // A clear command always releases the latch.
   a_clear_releases: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_bus.cmd) |=> !latch_ff)
      else $error("trip latch still set after a clear command");

   // The two arithmetic units never run at the same time.
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_stat.busy && div_stat.busy))
      else $error("multiplier and divider busy together");

   // A tripped result is only reported with the latch set.
   a_res_latched: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && res_ff) |-> latch_ff)
      else $error("tripped result without latch");
endmodule
